/* src/phb_pkg.sv */
package phb_pkg;

  localparam int HASH_W   = 24;
  localparam int BYTE_W   = 8;
  localparam int WIDE_W   = 32;
  localparam int QUO_W    = 9;
  localparam int BASE_W   = 9;
  localparam int CNT_W    = 5;
  localparam int RES_W    = 25;
  localparam int TOP_LSB  = 16;
  localparam int RECIP_W  = 17;
  localparam int Q_LSB    = 24;

  localparam logic [HASH_W-1:0]  HASH_MOD        = 24'd9999991;
  localparam logic [BASE_W-1:0]  HASH_BASE       = 9'd263;
  localparam logic [RECIP_W-1:0] HASH_RECIP      = 17'd109951;
  localparam logic [RES_W-1:0]   HASH_MOD_TWICE  = 25'd19999982;
  localparam int                 BUCKETS_AT_RESET = 521;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUO,
    ST_RED,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic quo;
    logic red;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic term;
    logic div_last;
  } dp_status_t;

endpackage

/* src/phb_ctrl.sv */
module phb_ctrl
  import phb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   emit_ok;

  assign emit_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.term ? ST_DIV : ST_QUO;
        end
      end
      ST_QUO:  state_next = ST_RED;
      ST_RED:  state_next = ST_IDLE;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_QUO:  cmd.quo = 1'b1;
      ST_RED:  cmd.red = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_EMIT: cmd.emit = emit_ok;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* src/phb_datapath.sv */
module phb_datapath
  import phb_pkg::*;
#(
  parameter int INDEX_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [BYTE_W-1:0]      key_byte,
  input  logic                   cfg_we,
  input  logic [INDEX_WIDTH-1:0] cfg_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output logic [HASH_W-1:0]      key_hash,
  output logic [INDEX_WIDTH-1:0] bucket_index
);

  logic [HASH_W-1:0]        hash_acc;
  logic [HASH_W-1:0]        power_acc;
  logic [INDEX_WIDTH-1:0]   bucket_count;
  logic [WIDE_W-1:0]        hsum;
  logic [WIDE_W-1:0]        psum;
  logic [QUO_W-1:0]         hq;
  logic [QUO_W-1:0]         pq;
  logic [HASH_W-1:0]        term_hash;
  logic [HASH_W-1:0]        dvd;
  logic [INDEX_WIDTH-1:0]   rem;
  logic [CNT_W-1:0]         cnt;

  logic [BYTE_W:0]          weight;
  logic [HASH_W+BYTE_W:0]   hprod;
  logic [HASH_W+BASE_W-1:0] pprod;
  logic [TOP_LSB+RECIP_W-1:0] hq_prod;
  logic [TOP_LSB+RECIP_W-1:0] pq_prod;
  logic [QUO_W+HASH_W-1:0]  hqm;
  logic [QUO_W+HASH_W-1:0]  pqm;
  logic [WIDE_W-1:0]        hres;
  logic [WIDE_W-1:0]        pres;
  logic [INDEX_WIDTH:0]     trial;
  logic [INDEX_WIDTH:0]     divisor;
  logic [INDEX_WIDTH-1:0]   rem_next;

  function automatic logic [HASH_W-1:0] mod_fix(input logic [WIDE_W-1:0] r);
    logic [RES_W-1:0] v;
    v = r[RES_W-1:0];
    if (v >= HASH_MOD_TWICE) begin
      v = v - HASH_MOD_TWICE;
    end else if (v >= RES_W'(HASH_MOD)) begin
      v = v - RES_W'(HASH_MOD);
    end
    return v[HASH_W-1:0];
  endfunction

  assign weight  = {1'b0, key_byte} + (BYTE_W+1)'(1);
  assign hprod   = weight * power_acc;
  assign pprod   = power_acc * HASH_BASE;
  assign hq_prod = hsum[WIDE_W-1:TOP_LSB] * HASH_RECIP;
  assign pq_prod = psum[WIDE_W-1:TOP_LSB] * HASH_RECIP;
  assign hqm     = hq * HASH_MOD;
  assign pqm     = pq * HASH_MOD;
  assign hres    = hsum - hqm[WIDE_W-1:0];
  assign pres    = psum - pqm[WIDE_W-1:0];

  assign divisor = {1'b0, bucket_count};
  assign trial   = {rem, dvd[HASH_W-1]};
  always_comb begin
    if (trial >= divisor) begin
      rem_next = INDEX_WIDTH'(trial - divisor);
    end else begin
      rem_next = trial[INDEX_WIDTH-1:0];
    end
  end

  assign status.term     = (key_byte == '0);
  assign status.div_last = (cnt == CNT_W'(HASH_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_acc     <= '0;
      power_acc    <= HASH_W'(1);
      bucket_count <= INDEX_WIDTH'(BUCKETS_AT_RESET);
      cnt          <= '0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_data;
      end
      if (cmd.take && status.term) begin
        hash_acc  <= '0;
        power_acc <= HASH_W'(1);
        cnt       <= '0;
      end else if (cmd.red) begin
        hash_acc  <= mod_fix(hres);
        power_acc <= mod_fix(pres);
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hsum      <= WIDE_W'(hash_acc) + hprod[WIDE_W-1:0];
      psum      <= pprod[WIDE_W-1:0];
      term_hash <= hash_acc;
      dvd       <= hash_acc;
      rem       <= '0;
    end
    if (cmd.quo) begin
      hq <= hq_prod[Q_LSB +: QUO_W];
      pq <= pq_prod[Q_LSB +: QUO_W];
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      dvd <= {dvd[HASH_W-2:0], 1'b0};
    end
    if (cmd.emit) begin
      key_hash     <= term_hash;
      bucket_index <= (bucket_count == '0) ? '0 : rem;
    end
  end

endmodule

/* src/polynomial_string_hash_bucket.sv */
// Polynomial rolling string hash with bucket selection. Key bytes arrive one per
// transaction; a zero byte ends the key and produces one result transaction carrying
// the hash modulo 9999991 and that hash modulo bucket_count (0 when bucket_count is
// 0). A nonzero byte occupies the block through the multiply, quotient estimate and
// reduction steps of the modular arithmetic. A terminator occupies it through the
// remainder unit, which takes in one bit of the 24-bit hash per cycle, then any wait
// for the output register to empty. A new byte is taken while a finished result
// still waits in the output register. bucket_count is written through cfg_we and
// cfg_data; the user must write it only while no key is in progress (not enforced).
module polynomial_string_hash_bucket
  import phb_pkg::*;
#(
  parameter int INDEX_WIDTH = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      key_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [HASH_W-1:0]      key_hash,
  output logic [INDEX_WIDTH-1:0] bucket_index,
  input  logic                   cfg_we,
  input  logic [INDEX_WIDTH-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  phb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  phb_datapath #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key_byte     (key_byte),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .key_hash     (key_hash),
    .bucket_index (bucket_index)
  );

endmodule

/* src/phb_checker.sv */
module phb_checker
  import phb_pkg::*;
#(
  parameter int INDEX_WIDTH = 20
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [BYTE_W-1:0]      key_byte,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [HASH_W-1:0]      key_hash,
  input logic [INDEX_WIDTH-1:0] bucket_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result transaction withdrawn before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(key_hash) && $stable(bucket_index))
    else $error("Result payload changed while stalled.");

  a_hash_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_hash < HASH_MOD)
    else $error("Hash is not reduced below the modulus.");

  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && key_byte != '0 |=> !in_ready)
    else $error("Next byte taken before the accumulators were updated.");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && key_byte != '0 |=> !$rose(out_valid))
    else $error("Result transaction raised by a nonzero byte.");

endmodule

bind polynomial_string_hash_bucket phb_checker #(
  .INDEX_WIDTH (INDEX_WIDTH)
) u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .key_byte     (key_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .key_hash     (key_hash),
  .bucket_index (bucket_index)
);
